// ===== sv/fasr_pkg.sv =====
// Package for the filtered serial receiver: register indexes, reset values,
// frame status codes and symbol numbers. No dependencies.
package fasr_pkg;

  // Window depth used when the top level is not told otherwise.
  localparam int unsigned DefWindowSamples = 32;

  // Configuration port widths.
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;
  localparam int unsigned TimeWidth     = 16;
  localparam int unsigned HystWidth     = 6;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] RegTickUs       = 3'd0;
  localparam logic [CfgIndexWidth-1:0] RegSampleUs     = 3'd1;
  localparam logic [CfgIndexWidth-1:0] RegHalfSymbolUs = 3'd2;
  localparam logic [CfgIndexWidth-1:0] RegSymbolUs     = 3'd3;
  localparam logic [CfgIndexWidth-1:0] RegHysteresis   = 3'd4;

  // Register values after reset.
  localparam logic [TimeWidth-1:0] RstTickUs       = 16'd128;
  localparam logic [TimeWidth-1:0] RstSampleUs     = 16'd128;
  localparam logic [TimeWidth-1:0] RstHalfSymbolUs = 16'd11000;
  localparam logic [TimeWidth-1:0] RstSymbolUs     = 16'd22000;
  localparam logic [HystWidth-1:0] RstHysteresis   = 6'd8;

  // Symbol numbers within a frame.
  localparam logic [3:0] SymIdle  = 4'd0;
  localparam logic [3:0] SymStart = 4'd1;
  localparam logic [3:0] SymStop  = 4'd10;

  // Frame status reported with each result.
  typedef enum logic [1:0] {
    StatusNone     = 2'd0,
    StatusStartErr = 2'd1,
    StatusStopErr  = 2'd2,
    StatusOk       = 2'd3
  } frame_status_e;

endpackage

// ===== sv/filtered_async_serial_receiver_unit.sv =====
// Filtered 8N1 serial receiver: sample window with hysteresis vote, edge
// detect and a midpoint-sampling frame decoder. Depends on fasr_pkg.
//
// An input item passes the input register, then the result register, before its result
// is offered. Throughput: one item per cycle while the result side is not stalled; all
// state is updated by one pass of short logic between the two registers.
// Reset clears the window, counters, frame state and the configuration
// registers to their default values; the configuration port never stalls.
module filtered_async_serial_receiver_unit
  import fasr_pkg::*;
#(
  parameter int unsigned WindowSamples = DefWindowSamples
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration writes.
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i,
  // Input items.
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     tick_i,
  input  logic                     line_level_i,
  // Result items.
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               frame_status_o,
  output logic [7:0]               received_byte_o,
  output logic                     busy_res_o,
  output logic                     filtered_level_o,
  output logic                     edge_seen_o
);

  localparam int unsigned PosWidth = $clog2(WindowSamples);
  localparam int unsigned CntWidth = $clog2(WindowSamples + 1);
  localparam int unsigned CmpWidth = ((CntWidth > HystWidth) ? CntWidth : HystWidth) + 1;
  localparam logic [PosWidth-1:0] LastPos = PosWidth'(WindowSamples - 1);

  // Configuration registers.
  logic [TimeWidth-1:0] tick_us_q, sample_us_q, half_us_q, symbol_us_q;
  logic [HystWidth-1:0] hyst_q;

  // Input and result stage handshake state.
  logic in_valid_q, out_valid_q, advance;
  logic tick_q, level_in_q;

  // Filter and decoder state.
  logic [WindowSamples-1:0] window_q, window_d;
  logic [CntWidth-1:0]      ones_q, ones_d;
  logic [PosWidth-1:0]      pos_q, pos_d;
  logic                     filt_q, filt_d;
  logic [TimeWidth-1:0]     sample_el_q, sample_el_d;
  logic [TimeWidth-1:0]     symbol_el_q, symbol_el_d;
  logic [3:0]               sym_num_q, sym_num_d;
  logic                     mid_done_q, mid_done_d;
  logic [7:0]               shift_q, shift_d;

  // Result computed for the item in the input register.
  frame_status_e            status_d;
  logic [7:0]               byte_d;
  logic                     edge_d;

  // Result register.
  logic [1:0]               status_q;
  logic [7:0]               byte_q;
  logic                     busy_q, level_out_q, edge_q;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;

  // One pass: window filter, then frame decoder.
  always_comb begin
    logic [TimeWidth-1:0] delta;
    logic [TimeWidth-1:0] sample_sum;
    logic [CmpWidth-1:0]  ones_w, zeros_w, hyst_w;
    logic                 sample_take;

    delta       = tick_q ? tick_us_q : '0;
    window_d    = window_q;
    ones_d      = ones_q;
    pos_d       = pos_q;
    filt_d      = filt_q;
    edge_d      = 1'b0;
    sym_num_d   = sym_num_q;
    mid_done_d  = mid_done_q;
    shift_d     = shift_q;
    status_d    = StatusNone;
    byte_d      = '0;

    // Sample timer and window update.
    sample_sum  = sample_el_q + delta;
    sample_take = (sample_sum >= sample_us_q);
    sample_el_d = sample_take ? (sample_sum - sample_us_q) : sample_sum;
    if (sample_take) begin
      ones_d = ones_q - CntWidth'(window_q[pos_q]) + CntWidth'(level_in_q);
      window_d[pos_q] = level_in_q;
      pos_d = (pos_q == LastPos) ? '0 : pos_q + 1'b1;
    end
    ones_w  = CmpWidth'(ones_d);
    zeros_w = CmpWidth'(WindowSamples) - ones_w;
    hyst_w  = CmpWidth'(hyst_q);

    // Majority vote with hysteresis against the previous level.
    if (sample_take) begin
      if (filt_q) begin
        filt_d = (zeros_w < ones_w + hyst_w);
      end else begin
        filt_d = (zeros_w + hyst_w < ones_w);
      end
      edge_d = (filt_d != filt_q);
    end

    // Symbol timer; a falling edge while idle opens a frame.
    symbol_el_d = symbol_el_q + delta;
    if (sym_num_q == SymIdle && edge_d && !filt_d) begin
      sym_num_d   = SymStart;
      mid_done_d  = 1'b0;
      symbol_el_d = '0;
    end

    // Midpoint check first, end of symbol otherwise.
    if (sym_num_d != SymIdle) begin
      if (!mid_done_d && symbol_el_d >= half_us_q) begin
        mid_done_d = 1'b1;
        if (sym_num_d == SymStart) begin
          if (filt_d) begin
            sym_num_d = SymIdle;
            status_d  = StatusStartErr;
          end
        end else if (sym_num_d == SymStop) begin
          sym_num_d = SymIdle;
          if (filt_d) begin
            status_d = StatusOk;
            byte_d   = shift_q;
          end else begin
            status_d = StatusStopErr;
          end
        end else begin
          shift_d = {shift_q[6:0], filt_d};
        end
      end else if (symbol_el_d >= symbol_us_q) begin
        sym_num_d   = sym_num_d + 4'd1;
        symbol_el_d = symbol_el_d - symbol_us_q;
        mid_done_d  = 1'b0;
      end
    end
  end

  // Control, configuration, filter and decoder state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_us_q   <= RstTickUs;
      sample_us_q <= RstSampleUs;
      half_us_q   <= RstHalfSymbolUs;
      symbol_us_q <= RstSymbolUs;
      hyst_q      <= RstHysteresis;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      window_q    <= '0;
      ones_q      <= '0;
      pos_q       <= '0;
      filt_q      <= 1'b0;
      sample_el_q <= '0;
      symbol_el_q <= '0;
      sym_num_q   <= SymIdle;
      mid_done_q  <= 1'b0;
      shift_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegTickUs:       tick_us_q   <= cfg_data_i;
          RegSampleUs:     sample_us_q <= cfg_data_i;
          RegHalfSymbolUs: half_us_q   <= cfg_data_i;
          RegSymbolUs:     symbol_us_q <= cfg_data_i;
          RegHysteresis:   hyst_q      <= cfg_data_i[HystWidth-1:0];
          default: ;
        endcase
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= advance || (out_valid_q && !out_ready_i);
      if (advance) begin
        window_q    <= window_d;
        ones_q      <= ones_d;
        pos_q       <= pos_d;
        filt_q      <= filt_d;
        sample_el_q <= sample_el_d;
        symbol_el_q <= symbol_el_d;
        sym_num_q   <= sym_num_d;
        mid_done_q  <= mid_done_d;
        shift_q     <= shift_d;
      end
    end
  end

  // Input and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      tick_q     <= tick_i;
      level_in_q <= line_level_i;
    end
    if (advance) begin
      status_q    <= status_d;
      byte_q      <= byte_d;
      busy_q      <= (sym_num_d != SymIdle);
      level_out_q <= filt_d;
      edge_q      <= edge_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_status_o   = status_q;
  assign received_byte_o  = byte_q;
  assign busy_res_o       = busy_q;
  assign filtered_level_o = level_out_q;
  assign edge_seen_o      = edge_q;

endmodule

// ===== tb/fasr_frame_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the filtered serial receiver: tracks register writes, predicts one
// result per accepted input item and compares every result transfer. Depends on fasr_pkg.
module fasr_frame_checker
  import fasr_pkg::*;
#(
  parameter int unsigned WindowSamples = DefWindowSamples
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic                     tick_i,
  input  logic                     line_level_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [1:0]               frame_status_i,
  input  logic [7:0]               received_byte_i,
  input  logic                     busy_res_i,
  input  logic                     filtered_level_i,
  input  logic                     edge_seen_i,
  output int                       fail_count_o,
  output int                       result_count_o
);

  typedef struct packed {
    frame_status_e status;
    logic [7:0]    data;
    logic          busy;
    logic          level;
    logic          level_flip;
  } rx_result_t;

  // Timing and filter settings.
  logic [TimeWidth-1:0] tick_us;
  logic [TimeWidth-1:0] sample_us;
  logic [TimeWidth-1:0] half_us;
  logic [TimeWidth-1:0] symbol_us;
  logic [HystWidth-1:0] hyst;

  // Line filter and frame decoder state.
  logic                 window_bits [WindowSamples];
  int unsigned          ones_total;
  int unsigned          win_pos;
  logic                 filt_level;
  logic [TimeWidth-1:0] sample_acc;
  logic [TimeWidth-1:0] symbol_acc;
  logic [3:0]           symbol_idx;
  logic                 mid_taken;
  logic [7:0]           shift_reg;

  // Results owed for items already accepted, oldest first.
  rx_result_t rx_results_due [$];

  // Advances the receiver by one polling pass and returns what it reports.
  function automatic rx_result_t step_line_receiver(logic tick, logic line);
    logic [TimeWidth-1:0] delta;
    int                   ones;
    int                   zeros;
    logic                 next_level;
    rx_result_t           res;
    delta          = tick ? tick_us : '0;
    res.status     = StatusNone;
    res.data       = '0;
    res.level_flip = 1'b0;

    // A new sample replaces the oldest one in the window, then the vote is taken.
    sample_acc = sample_acc + delta;
    if (sample_acc >= sample_us) begin
      sample_acc = sample_acc - sample_us;
      if (window_bits[win_pos]) ones_total--;
      window_bits[win_pos] = line;
      if (line) ones_total++;
      win_pos = (win_pos + 1) % WindowSamples;
      ones  = ones_total;
      zeros = int'(WindowSamples) - ones;
      if (filt_level) begin
        next_level = (zeros < ones + int'(hyst));
      end else begin
        next_level = (zeros + int'(hyst) < ones);
      end
      res.level_flip = (next_level != filt_level);
      filt_level     = next_level;
    end
    res.level = filt_level;

    // A falling edge while idle opens a frame; its midpoint check may fire at once.
    symbol_acc = symbol_acc + delta;
    if (symbol_idx == SymIdle && res.level_flip && !filt_level) begin
      symbol_idx = SymStart;
      mid_taken  = 1'b0;
      symbol_acc = '0;
    end

    // The midpoint check has priority; only without it can the symbol end.
    if (symbol_idx != SymIdle) begin
      if (!mid_taken && symbol_acc >= half_us) begin
        mid_taken = 1'b1;
        if (symbol_idx == SymStart) begin
          if (filt_level) begin
            symbol_idx = SymIdle;
            res.status = StatusStartErr;
          end
        end else if (symbol_idx == SymStop) begin
          symbol_idx = SymIdle;
          if (filt_level) begin
            res.status = StatusOk;
            res.data   = shift_reg;
          end else begin
            res.status = StatusStopErr;
          end
        end else begin
          shift_reg = {shift_reg[6:0], filt_level};
        end
      end else if (symbol_acc >= symbol_us) begin
        // The count wraps past the stop symbol back to idle with no status.
        symbol_idx = symbol_idx + 4'd1;
        symbol_acc = symbol_acc - symbol_us;
        mid_taken  = 1'b0;
      end
    end
    res.busy = (symbol_idx != SymIdle);
    return res;
  endfunction

  // Register writes, result comparison and prediction, all at the clock edge.
  always @(posedge clk_i or negedge rst_ni) begin
    rx_result_t due;
    if (!rst_ni) begin
      tick_us        = RstTickUs;
      sample_us      = RstSampleUs;
      half_us        = RstHalfSymbolUs;
      symbol_us      = RstSymbolUs;
      hyst           = RstHysteresis;
      window_bits    = '{default: 1'b0};
      ones_total     = 0;
      win_pos        = 0;
      filt_level     = 1'b0;
      sample_acc     = '0;
      symbol_acc     = '0;
      symbol_idx     = SymIdle;
      mid_taken      = 1'b0;
      shift_reg      = '0;
      fail_count_o   = 0;
      result_count_o <= 0;
      rx_results_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegTickUs:       tick_us   = cfg_data_i;
          RegSampleUs:     sample_us = cfg_data_i;
          RegHalfSymbolUs: half_us   = cfg_data_i;
          RegSymbolUs:     symbol_us = cfg_data_i;
          RegHysteresis:   hyst      = cfg_data_i[HystWidth-1:0];
          default: ;
        endcase
      end

      // Each result transfer is matched against the oldest owed result.
      if (out_valid_i && out_ready_i) begin
        result_count_o <= result_count_o + 1;
        if (rx_results_due.size() == 0) begin
          $error("result transfer with no input item outstanding");
          fail_count_o++;
        end else begin
          due = rx_results_due.pop_front();
          if (frame_status_i !== due.status) begin
            $error("frame_status: expected %0d, actual %0d", due.status, frame_status_i);
            fail_count_o++;
          end
          if (received_byte_i !== due.data) begin
            $error("received_byte: expected 0x%02h, actual 0x%02h", due.data, received_byte_i);
            fail_count_o++;
          end
          if (busy_res_i !== due.busy) begin
            $error("busy_res: expected %0b, actual %0b", due.busy, busy_res_i);
            fail_count_o++;
          end
          if (filtered_level_i !== due.level) begin
            $error("filtered_level: expected %0b, actual %0b", due.level, filtered_level_i);
            fail_count_o++;
          end
          if (edge_seen_i !== due.level_flip) begin
            $error("edge_seen: expected %0b, actual %0b", due.level_flip, edge_seen_i);
            fail_count_o++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        rx_results_due.push_back(step_line_receiver(tick_i, line_level_i));
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the filtered serial receiver testbench: clock, reset, register setup, serial
// frame stimulus and the verdict. Depends on fasr_pkg, the receiver and fasr_frame_checker.
module tb_top;
  import fasr_pkg::*;

  localparam int unsigned HoldCycles   = 80;
  localparam int unsigned SegmentItems = 25;
  localparam int          CycleLimit   = 100000;
  localparam logic [CfgIndexWidth-1:0] RegUnused = RegHysteresis + 3'd1;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CfgIndexWidth-1:0] cfg_index_i;
  logic [CfgDataWidth-1:0]  cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic                     tick_i;
  logic                     line_level_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [1:0]               frame_status_o;
  logic [7:0]               received_byte_o;
  logic                     busy_res_o;
  logic                     filtered_level_o;
  logic                     edge_seen_o;

  int fail_count;
  int result_count;
  int items_sent   = 0;
  int cycle_count  = 0;
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int hold_from    = -1;
  bit hold_done    = 1'b0;

  filtered_async_serial_receiver_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .tick_i           (tick_i),
    .line_level_i     (line_level_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_status_o   (frame_status_o),
    .received_byte_o  (received_byte_o),
    .busy_res_o       (busy_res_o),
    .filtered_level_o (filtered_level_o),
    .edge_seen_o      (edge_seen_o)
  );

  fasr_frame_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .tick_i           (tick_i),
    .line_level_i     (line_level_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_status_i   (frame_status_o),
    .received_byte_i  (received_byte_o),
    .busy_res_i       (busy_res_o),
    .filtered_level_i (filtered_level_o),
    .edge_seen_i      (edge_seen_o),
    .fail_count_o     (fail_count),
    .result_count_o   (result_count)
  );

  // Free-running clock, 4 ns period.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off once items are flowing.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && hold_from >= 0 && items_sent >= hold_from) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // One register write transfer; valid is left high for a following write.
  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_setting(input logic [CfgDataWidth-1:0] tick_us, sample_us, half_us,
                              sym_us, hyst_word);
    write_reg(RegTickUs, tick_us);
    write_reg(RegSampleUs, sample_us);
    write_reg(RegHalfSymbolUs, half_us);
    write_reg(RegSymbolUs, sym_us);
    write_reg(RegHysteresis, hyst_word);
    cfg_valid_i <= 1'b0;
  endtask

  // One input transfer, after a random number of idle cycles.
  task automatic send_item(input logic tick, input logic line);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    tick_i       <= tick;
    line_level_i <= line;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // Holds the raw line at one level for n items, with rare glitches and missed ticks.
  task automatic hold_line(input logic level, input int n);
    repeat (n) send_item($urandom_range(0, 9) != 0, level ^ ($urandom_range(0, 39) == 0));
  endtask

  // Stops offering items and waits until every result has been taken.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (result_count < items_sent) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One setting followed by serial frames with random content, broken starts and noise.
  task automatic run_segment(input logic [CfgDataWidth-1:0] tick_us, sample_us, half_us,
                             sym_us, hyst_word, input int sym_items);
    int         first_item;
    logic [7:0] data_bits;
    load_setting(tick_us, sample_us, half_us, sym_us, hyst_word);
    first_item = items_sent;
    while (items_sent - first_item < SegmentItems) begin
      case ($urandom_range(0, 7))
        0, 1: begin
          repeat ($urandom_range(4, 24)) begin
            send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          end
        end
        2: begin
          // Low pulse long enough to move the filter and at least as long as a start bit.
          hold_line(1'b1, $urandom_range(4, 24));
          hold_line(1'b0, $urandom_range(12, 20));
        end
        default: begin
          // Idle mark, start bit, data MSB first, stop bit that is sometimes low.
          data_bits = 8'($urandom);
          hold_line(1'b1, $urandom_range(4, 24));
          hold_line(1'b0, sym_items);
          for (int b = 7; b >= 0; b--) hold_line(data_bits[b], sym_items);
          hold_line($urandom_range(0, 4) != 0, sym_items);
        end
      endcase
    end
    wait_idle();
  endtask

  // Main sequence.
  initial begin
    rst_ni       <= 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= RegTickUs;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    tick_i       <= 1'b0;
    line_level_i <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: settings after reset, then both timing extremes with every field value.
    in_idle_pct  = 36;
    out_idle_pct = 55;
    for (int i = 0; i < 8; i++) send_item(i[0], i[1]);
    wait_idle();
    load_setting(16'hFFFF, 16'd1, 16'd1, 16'd2, 16'd32);
    for (int i = 0; i < 8; i++) send_item(i[1], i[0] ^ i[2]);
    wait_idle();
    load_setting(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    for (int i = 0; i < 8; i++) send_item(!i[0], i[1]);
    wait_idle();

    // Random frames; the second setting samples every item and never reaches a midpoint.
    run_segment(16'd128, 16'd128, 16'd512, 16'd1024, 16'd8, 8);
    run_segment(16'd1, 16'd0, 16'd40, 16'd12, 16'd0, 12);

    // Midpoint at the frame's first item, and a sample accumulator that keeps growing.
    in_idle_pct  = 55;
    out_idle_pct = 36;
    run_segment(16'd5000, 16'd4000, 16'd0, 16'd40000, 16'd2, 8);
    run_segment(16'd3, 16'd2, 16'd15, 16'd30, 16'd4, 10);

    // Full rate, with one long result hold-off and a hysteresis word with high bits set.
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_from    = items_sent + 10;
    run_segment(16'd1, 16'd1, 16'd4, 16'd8, 16'hFF01, 8);
    write_reg(RegUnused, 16'hBEEF);
    run_segment(16'd100, 16'd100, 16'd500, 16'd1000, 16'd0, 10);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
